// ===== sv/msec_pkg.sv =====
package msec_pkg;

	localparam logic [5:0] OP_RTYPE = 6'h00;
	localparam logic [5:0] OP_J     = 6'h02;
	localparam logic [5:0] OP_BEQ   = 6'h04;
	localparam logic [5:0] OP_ADDI  = 6'h08;
	localparam logic [5:0] OP_LW    = 6'h23;
	localparam logic [5:0] OP_SW    = 6'h2B;

	localparam logic [5:0] FN_ADD = 6'h20;
	localparam logic [5:0] FN_SUB = 6'h22;
	localparam logic [5:0] FN_AND = 6'h24;
	localparam logic [5:0] FN_OR  = 6'h25;
	localparam logic [5:0] FN_SLT = 6'h2A;

	typedef enum logic [2:0] {
		OPC_NOP,
		OPC_ALU,
		OPC_ADDI,
		OPC_LW,
		OPC_SW,
		OPC_BEQ,
		OPC_J,
		OPC_ILL
	} op_cls_t;

	typedef enum logic [2:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_AND,
		ALU_OR,
		ALU_SLT
	} alu_op_t;

	typedef struct packed {
		op_cls_t     cls;
		alu_op_t     alu;
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic [4:0]  dest;
		logic        wr;
		logic        use_a;
		logic        use_b;
		logic [25:0] imm;
	} dec_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic        reg_write;
		logic [4:0]  reg_dest;
		logic [31:0] reg_value;
		logic        store_done;
		logic        branch_taken;
		logic        illegal;
	} res_t;

endpackage

// ===== sv/mips_subset_execute_core_top.sv =====
// Throughput: one instruction per cycle while the result queue has room; an instruction
// that reads the target of a load up to three places ahead waits for the load data,
// which lies behind the three-stage address reduction in front of the data-memory port.
// Reset: register-file valid bits and program counter clear at once, so registers read
// as zero; full stays high while the data memory is cleared one word per cycle.
module mips_subset_execute_core_top #(
	parameter int DMEM_WORDS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] instruction_word,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] next_pc,
	output logic        reg_write,
	output logic [4:0]  reg_dest,
	output logic [31:0] reg_value,
	output logic        store_done,
	output logic        branch_taken,
	output logic        illegal
);

	import msec_pkg::*;

	logic  fq_full;
	logic  head_valid;
	logic  head_pop;
	dec_t  head;
	logic  res_push;
	logic  res_full;
	res_t  res_in;
	res_t  res_out;
	logic  clr_busy;

	assign full = fq_full || clr_busy;

	msec_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push && !full),
		.instruction_word (instruction_word),
		.full             (fq_full),
		.pop              (head_pop),
		.head             (head),
		.head_valid       (head_valid)
	);

	msec_back #(
		.DMEM_WORDS(DMEM_WORDS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop),
		.res_push   (res_push),
		.res        (res_in),
		.res_full   (res_full),
		.clr_busy   (clr_busy)
	);

	msec_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(2)
	) u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign next_pc      = res_out.next_pc;
	assign reg_write    = res_out.reg_write;
	assign reg_dest     = res_out.reg_dest;
	assign reg_value    = res_out.reg_value;
	assign store_done   = res_out.store_done;
	assign branch_taken = res_out.branch_taken;
	assign illegal      = res_out.illegal;

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> empty)
		else $error("result present during data memory clear");

	a_illegal_no_effect: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && illegal) |-> (!reg_write && !store_done && !branch_taken))
		else $error("illegal instruction with side effect");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !reg_write) |-> (reg_dest == '0 && reg_value == '0))
		else $error("writeback fields set without a write");

	a_write_not_r0: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && reg_write) |-> (reg_dest != '0))
		else $error("write to register zero");

endmodule

// ===== sv/msec_fifo.sv =====
module msec_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/msec_front.sv =====
module msec_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  logic [31:0]    instruction_word,
	output logic           full,
	input  logic           pop,
	output msec_pkg::dec_t head,
	output logic           head_valid
);

	import msec_pkg::*;

	dec_t       dec;
	logic [5:0] op;
	logic [5:0] fn;
	logic       head_empty;

	assign op = instruction_word[31:26];
	assign fn = instruction_word[5:0];

	always_comb begin
		dec       = '0;
		dec.cls   = OPC_ILL;
		dec.alu   = ALU_ADD;
		dec.rs    = instruction_word[25:21];
		dec.rt    = instruction_word[20:16];
		dec.imm   = instruction_word[25:0];
		unique case (op)
			OP_RTYPE: begin
				dec.cls   = OPC_ALU;
				dec.dest  = instruction_word[15:11];
				dec.use_a = 1'b1;
				dec.use_b = 1'b1;
				unique case (fn)
					FN_ADD:  dec.alu = ALU_ADD;
					FN_SUB:  dec.alu = ALU_SUB;
					FN_AND:  dec.alu = ALU_AND;
					FN_OR:   dec.alu = ALU_OR;
					FN_SLT:  dec.alu = ALU_SLT;
					default: begin
						dec.cls   = (instruction_word == '0) ? OPC_NOP : OPC_ILL;
						dec.use_a = 1'b0;
						dec.use_b = 1'b0;
					end
				endcase
			end
			OP_ADDI: begin
				dec.cls   = OPC_ADDI;
				dec.dest  = instruction_word[20:16];
				dec.use_a = 1'b1;
			end
			OP_LW: begin
				dec.cls   = OPC_LW;
				dec.dest  = instruction_word[20:16];
				dec.use_a = 1'b1;
			end
			OP_SW: begin
				dec.cls   = OPC_SW;
				dec.use_a = 1'b1;
				dec.use_b = 1'b1;
			end
			OP_BEQ: begin
				dec.cls   = OPC_BEQ;
				dec.use_a = 1'b1;
				dec.use_b = 1'b1;
			end
			OP_J: begin
				dec.cls = OPC_J;
			end
			default: begin
				dec.cls = OPC_ILL;
			end
		endcase
		dec.wr = (dec.cls == OPC_ALU || dec.cls == OPC_ADDI || dec.cls == OPC_LW)
			&& (dec.dest != '0);
		if (!dec.wr) begin
			dec.dest = '0;
		end
	end

	msec_fifo #(
		.WIDTH($bits(dec_t)),
		.DEPTH(2)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (dec),
		.full   (full),
		.pop    (pop),
		.rdata  (head),
		.empty  (head_empty)
	);

	assign head_valid = !head_empty;

endmodule

// ===== sv/msec_back.sv =====
module msec_back #(
	parameter int DMEM_WORDS = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  msec_pkg::dec_t head,
	output logic           head_pop,
	output logic           res_push,
	output msec_pkg::res_t res,
	input  logic           res_full,
	output logic           clr_busy
);

	import msec_pkg::*;

	localparam int AW = $clog2(DMEM_WORDS);
	localparam int MW = 34 - AW;
	localparam longint unsigned RECIP = (64'd1 << 32) / DMEM_WORDS;
	localparam logic [MW-1:0] RECIP_C = MW'(RECIP);
	localparam logic [AW:0] DW = (AW + 1)'(DMEM_WORDS);

	typedef struct packed {
		logic        wr;
		logic [4:0]  dest;
		logic [31:0] val;
		logic        ld;
		logic        st;
		logic [31:0] npc;
		logic        tk;
		logic        ill;
	} pipe_t;

	logic          adv;
	logic          hazard;
	logic          v_s1, v_s2, v_s3, v_s4, v_s5;
	dec_t          dec_s1;
	logic [31:0]   rda_s1, rdb_s1, wbv_s1;
	logic          vla_s1, vlb_s1, bya_s1, byb_s1;
	pipe_t         p_ex, p_s2, p_s3, p_s4, p_s5;
	logic [31:0]   eff_s2, eff_s3, eff_s4;
	logic [MW-1:0] q_s3;
	logic [31:0]   qd_s4;

	logic [31:0]   rf_mem [32];
	logic [31:0]   rf_vld_q;
	logic [31:0]   pc_q;
	logic [31:0]   dm_mem [DMEM_WORDS];
	logic [31:0]   dm_rdata_q;
	logic          clr_busy_q;
	logic [AW-1:0] clr_idx_q;

	logic [31:0]      a, b, imm32, pc4, eff;
	logic             wb_en;
	logic [31:0]      wb_val;
	logic [31+MW:0]   prod;
	logic [MW+AW:0]   qd_full;
	logic [31:0]      r0;
	logic [AW:0]      r_lo;
	logic [AW-1:0]    dm_idx;

	function automatic logic ld_hit(input logic [4:0] idx);
		ld_hit = (v_s1 && dec_s1.cls == OPC_LW && dec_s1.wr && dec_s1.dest == idx)
			|| (v_s2 && p_s2.ld && p_s2.wr && p_s2.dest == idx)
			|| (v_s3 && p_s3.ld && p_s3.wr && p_s3.dest == idx);
	endfunction

	function automatic logic [31:0] fwd(input logic [4:0] idx, input logic [31:0] rd,
		input logic vl, input logic by);
		priority if (v_s2 && p_s2.wr && p_s2.dest == idx) begin
			fwd = p_s2.val;
		end else if (v_s3 && p_s3.wr && p_s3.dest == idx) begin
			fwd = p_s3.val;
		end else if (v_s4 && p_s4.wr && p_s4.dest == idx) begin
			fwd = p_s4.val;
		end else if (v_s5 && p_s5.wr && p_s5.dest == idx) begin
			fwd = wb_val;
		end else if (by) begin
			fwd = wbv_s1;
		end else if (vl) begin
			fwd = rd;
		end else begin
			fwd = '0;
		end
	endfunction

	// hold the whole pipe while the last result cannot leave
	assign adv      = !(v_s5 && res_full);
	always_comb begin
		hazard = (head.use_a && ld_hit(head.rs)) || (head.use_b && ld_hit(head.rt));
	end
	assign head_pop = adv && head_valid && !hazard;
	assign clr_busy = clr_busy_q;

	assign wb_en  = adv && v_s5 && p_s5.wr;
	assign wb_val = p_s5.ld ? dm_rdata_q : p_s5.val;

	always_comb begin
		a     = fwd(dec_s1.rs, rda_s1, vla_s1, bya_s1);
		b     = fwd(dec_s1.rt, rdb_s1, vlb_s1, byb_s1);
		imm32 = {{16{dec_s1.imm[15]}}, dec_s1.imm[15:0]};
		pc4   = pc_q + 32'd4;
		eff   = a + imm32;
		p_ex      = '0;
		p_ex.wr   = dec_s1.wr;
		p_ex.dest = dec_s1.dest;
		p_ex.npc  = pc4;
		unique case (dec_s1.cls)
			OPC_ALU: begin
				unique case (dec_s1.alu)
					ALU_ADD: p_ex.val = a + b;
					ALU_SUB: p_ex.val = a - b;
					ALU_AND: p_ex.val = a & b;
					ALU_OR:  p_ex.val = a | b;
					ALU_SLT: p_ex.val = {31'b0, $signed(a) < $signed(b)};
					default: p_ex.val = '0;
				endcase
			end
			OPC_ADDI: p_ex.val = eff;
			OPC_LW:   p_ex.ld = 1'b1;
			OPC_SW: begin
				p_ex.st  = 1'b1;
				p_ex.val = b;
			end
			OPC_BEQ: begin
				if (a == b) begin
					p_ex.tk  = 1'b1;
					p_ex.npc = pc4 + {imm32[29:0], 2'b00};
				end
			end
			OPC_J:   p_ex.npc = {pc4[31:28], dec_s1.imm, 2'b00};
			OPC_ILL: begin
				p_ex.ill = 1'b1;
				p_ex.npc = pc_q;
			end
			OPC_NOP: begin
			end
		endcase
	end

	// word index: reciprocal estimate, then one correcting subtract
	assign prod    = (32 + MW)'(eff_s2) * (32 + MW)'(RECIP_C);
	assign qd_full = (MW + AW + 1)'(q_s3) * (MW + AW + 1)'(DW);
	assign r0      = eff_s4 - qd_s4;
	assign r_lo    = r0[AW:0];
	assign dm_idx  = (r_lo >= DW) ? AW'(r_lo - DW) : r_lo[AW-1:0];

	always_ff @(posedge clk) begin
		if (adv && head_pop) begin
			dec_s1 <= head;
			rda_s1 <= rf_mem[head.rs];
			rdb_s1 <= rf_mem[head.rt];
			vla_s1 <= rf_vld_q[head.rs];
			vlb_s1 <= rf_vld_q[head.rt];
			bya_s1 <= wb_en && (p_s5.dest == head.rs);
			byb_s1 <= wb_en && (p_s5.dest == head.rt);
			wbv_s1 <= wb_val;
		end
		if (wb_en) begin
			rf_mem[p_s5.dest] <= wb_val;
		end
		if (adv) begin
			p_s2   <= p_ex;
			eff_s2 <= eff;
			p_s3   <= p_s2;
			eff_s3 <= eff_s2;
			q_s3   <= prod[31+MW:32];
			p_s4   <= p_s3;
			eff_s4 <= eff_s3;
			qd_s4  <= qd_full[31:0];
			p_s5   <= p_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			dm_mem[clr_idx_q] <= '0;
		end else if (adv && v_s4 && p_s4.st) begin
			dm_mem[dm_idx] <= p_s4.val;
		end
		if (adv && v_s4 && p_s4.ld) begin
			dm_rdata_q <= dm_mem[dm_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			v_s5       <= 1'b0;
			rf_vld_q   <= '0;
			pc_q       <= '0;
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else begin
			if (adv) begin
				v_s1 <= head_pop;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
				v_s5 <= v_s4;
				if (v_s1) begin
					pc_q <= p_ex.npc;
				end
			end
			if (wb_en) begin
				rf_vld_q[p_s5.dest] <= 1'b1;
			end
			if (clr_busy_q) begin
				if (clr_idx_q == AW'(DMEM_WORDS - 1)) begin
					clr_busy_q <= 1'b0;
				end else begin
					clr_idx_q <= clr_idx_q + 1'b1;
				end
			end
		end
	end

	assign res_push         = adv && v_s5;
	assign res.next_pc      = p_s5.npc;
	assign res.reg_write    = p_s5.wr;
	assign res.reg_dest     = p_s5.dest;
	assign res.reg_value    = p_s5.wr ? wb_val : '0;
	assign res.store_done   = p_s5.st;
	assign res.branch_taken = p_s5.tk;
	assign res.illegal      = p_s5.ill;

endmodule

// ===== bench/mips_subset_execute_core_top_tb.sv =====
class core_retire_checker #(int MEM_WORDS = 1024);

	logic [31:0] regs [32];
	logic [31:0] mem [MEM_WORDS];
	logic [31:0] pc;
	msec_pkg::res_t expected_retires [$];
	int errors;
	int retired;

	function new();
		foreach (regs[i]) regs[i] = '0;
		foreach (mem[i]) mem[i] = '0;
		pc = '0;
		errors = 0;
		retired = 0;
	endfunction

	function msec_pkg::res_t execute(logic [31:0] w);
		msec_pkg::res_t r;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] imm;
		logic [31:0] pc4;
		logic [31:0] npc;
		logic [31:0] ea;
		logic [31:0] val;
		logic [4:0] dst;
		logic wr;
		logic st;
		logic tk;
		logic bad;
		a = regs[w[25:21]];
		b = regs[w[20:16]];
		imm = {{16{w[15]}}, w[15:0]};
		pc4 = pc + 32'd4;
		npc = pc4;
		ea = a + imm;
		val = '0;
		dst = '0;
		wr = 1'b0;
		st = 1'b0;
		tk = 1'b0;
		bad = 1'b0;
		case (w[31:26])
			msec_pkg::OP_RTYPE: begin
				dst = w[15:11];
				wr = 1'b1;
				case (w[5:0])
					msec_pkg::FN_ADD: val = a + b;
					msec_pkg::FN_SUB: val = a - b;
					msec_pkg::FN_AND: val = a & b;
					msec_pkg::FN_OR:  val = a | b;
					msec_pkg::FN_SLT: val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
					default: begin
						wr = 1'b0;
						bad = (w != '0);
					end
				endcase
			end
			msec_pkg::OP_ADDI: begin
				dst = w[20:16];
				wr = 1'b1;
				val = ea;
			end
			msec_pkg::OP_LW: begin
				dst = w[20:16];
				wr = 1'b1;
				val = mem[ea % 32'(MEM_WORDS)];
			end
			msec_pkg::OP_SW: begin
				mem[ea % 32'(MEM_WORDS)] = b;
				st = 1'b1;
			end
			msec_pkg::OP_BEQ: begin
				if (a == b) begin
					tk = 1'b1;
					npc = pc4 + (imm << 2);
				end
			end
			msec_pkg::OP_J: npc = {pc4[31:28], w[25:0], 2'b00};
			default: bad = 1'b1;
		endcase
		if (bad) begin
			npc = pc;
			wr = 1'b0;
		end
		if (!wr || dst == 5'd0) begin
			wr = 1'b0;
			dst = '0;
			val = '0;
		end else begin
			regs[dst] = val;
		end
		pc = npc;
		r.next_pc = npc;
		r.reg_write = wr;
		r.reg_dest = dst;
		r.reg_value = val;
		r.store_done = st;
		r.branch_taken = tk;
		r.illegal = bad;
		return r;
	endfunction

	function void note_issue(logic [31:0] w);
		expected_retires.push_back(execute(w));
	endfunction

	function int outstanding();
		return expected_retires.size();
	endfunction

	task report_mismatch(string msg);
		$display("MISMATCH at retire %0d: %s", retired, msg);
		errors++;
	endtask

	task compare_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	task check_retire(msec_pkg::res_t got);
		msec_pkg::res_t want;
		if (expected_retires.size() == 0) begin
			report_mismatch("result with no instruction outstanding");
		end else begin
			want = expected_retires.pop_front();
			compare_field("next_pc", got.next_pc, want.next_pc);
			compare_field("reg_write", 32'(got.reg_write), 32'(want.reg_write));
			compare_field("reg_dest", 32'(got.reg_dest), 32'(want.reg_dest));
			compare_field("reg_value", got.reg_value, want.reg_value);
			compare_field("store_done", 32'(got.store_done), 32'(want.store_done));
			compare_field("branch_taken", 32'(got.branch_taken), 32'(want.branch_taken));
			compare_field("illegal", 32'(got.illegal), 32'(want.illegal));
		end
		retired++;
	endtask

endclass

module mips_subset_execute_core_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import msec_pkg::*;

	localparam int DMEM_WORDS = 1024;
	localparam int RANDOM_WORDS = 650;
	localparam int HOLD_CYCLES = 400;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [31:0] instruction_word;
	logic        empty;
	logic        pop;
	logic [31:0] next_pc;
	logic        reg_write;
	logic [4:0]  reg_dest;
	logic [31:0] reg_value;
	logic        store_done;
	logic        branch_taken;
	logic        illegal;

	core_retire_checker #(DMEM_WORDS) sb;

	mips_subset_execute_core_top #(.DMEM_WORDS(DMEM_WORDS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.instruction_word(instruction_word),
		.empty(empty),
		.pop(pop),
		.next_pc(next_pc),
		.reg_write(reg_write),
		.reg_dest(reg_dest),
		.reg_value(reg_value),
		.store_done(store_done),
		.branch_taken(branch_taken),
		.illegal(illegal)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

	function automatic logic [31:0] r_word(logic [5:0] fn, logic [4:0] rd, logic [4:0] rs,
			logic [4:0] rt);
		return {OP_RTYPE, rs, rt, rd, 5'd0, fn};
	endfunction

	function automatic logic [31:0] i_word(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
			logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic logic [31:0] j_word(logic [25:0] target);
		return {OP_J, target};
	endfunction

	function automatic logic [4:0] pick_reg();
		return ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 7)) : 5'($urandom);
	endfunction

	function automatic logic [4:0] pick_base();
		return ($urandom_range(0, 1) != 0) ? 5'd0 : pick_reg();
	endfunction

	function automatic logic [15:0] pick_offset();
		int unsigned sel;
		sel = $urandom_range(0, 3);
		if (sel < 2)
			return 16'($urandom_range(0, 31));
		else if (sel == 2)
			return 16'hFFFF - 16'($urandom_range(0, 31));
		return 16'($urandom);
	endfunction

	function automatic logic [31:0] random_word();
		logic [5:0] alu_fns [5];
		logic [5:0] op;
		logic [5:0] fn;
		logic [4:0] rs;
		logic [31:0] w;
		int unsigned kind;
		alu_fns = '{FN_ADD, FN_SUB, FN_AND, FN_OR, FN_SLT};
		kind = $urandom_range(0, 99);
		rs = pick_reg();
		if (kind < 30) begin
			w = {OP_RTYPE, rs, pick_reg(), pick_reg(), 5'($urandom),
				alu_fns[$urandom_range(0, 4)]};
		end else if (kind < 42) begin
			w = i_word(OP_ADDI, rs, pick_reg(), 16'($urandom));
		end else if (kind < 56) begin
			w = i_word(OP_LW, pick_base(), pick_reg(), pick_offset());
		end else if (kind < 68) begin
			w = i_word(OP_SW, pick_base(), pick_reg(), pick_offset());
		end else if (kind < 80) begin
			w = i_word(OP_BEQ, rs, ($urandom_range(0, 1) != 0) ? rs : pick_reg(), 16'($urandom));
		end else if (kind < 85) begin
			w = j_word(26'($urandom));
		end else if (kind < 88) begin
			w = '0;
		end else if (kind < 92) begin
			do fn = 6'($urandom); while (fn inside {FN_ADD, FN_SUB, FN_AND, FN_OR, FN_SLT});
			w = {OP_RTYPE, 20'($urandom), fn};
			if (w == '0)
				w[6] = 1'b1;
		end else if (kind < 96) begin
			do op = 6'($urandom);
			while (op inside {OP_RTYPE, OP_J, OP_BEQ, OP_ADDI, OP_LW, OP_SW});
			w = {op, 26'($urandom)};
		end else begin
			w = $urandom;
		end
		return w;
	endfunction

	task automatic send_word(input logic [31:0] w, input int gap);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		instruction_word <= w;
		do @(posedge clk); while (full);
		sb.note_issue(w);
		@(negedge clk);
	endtask

	task automatic take_results();
		res_t got;
		int taken;
		int stall;
		taken = 0;
		forever begin
			if (taken == 250)
				stall = HOLD_CYCLES;
			else if (taken >= 400 && taken < 480)
				stall = 0;
			else
				stall = $urandom_range(0, 9);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			got.next_pc = next_pc;
			got.reg_write = reg_write;
			got.reg_dest = reg_dest;
			got.reg_value = reg_value;
			got.store_done = store_done;
			got.branch_taken = branch_taken;
			got.illegal = illegal;
			sb.check_retire(got);
			taken++;
			@(negedge clk);
		end
	endtask

	initial begin
		logic [31:0] directed [$];
		int gap;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		instruction_word = '0;
		sb = new();
		directed = '{
			32'h0000_0000,
			i_word(OP_ADDI, 5'd0, 5'd1, 16'h7FFF),
			i_word(OP_ADDI, 5'd0, 5'd2, 16'h8000),
			i_word(OP_ADDI, 5'd0, 5'd3, 16'hFFFF),
			r_word(FN_ADD, 5'd4, 5'd3, 5'd3),
			r_word(FN_SUB, 5'd5, 5'd2, 5'd1),
			r_word(FN_AND, 5'd6, 5'd3, 5'd1),
			r_word(FN_OR, 5'd7, 5'd2, 5'd1),
			r_word(FN_SLT, 5'd8, 5'd2, 5'd1),
			r_word(FN_SLT, 5'd9, 5'd1, 5'd2),
			r_word(FN_ADD, 5'd0, 5'd1, 5'd1),
			i_word(OP_ADDI, 5'd1, 5'd0, 16'h0001),
			i_word(OP_SW, 5'd0, 5'd1, 16'h0004),
			i_word(OP_LW, 5'd0, 5'd10, 16'h0004),
			r_word(FN_ADD, 5'd11, 5'd10, 5'd10),
			i_word(OP_SW, 5'd0, 5'd3, 16'hFFFC),
			i_word(OP_LW, 5'd0, 5'd12, 16'd1020),
			i_word(OP_LW, 5'd0, 5'd0, 16'h0004),
			i_word(OP_BEQ, 5'd0, 5'd0, 16'h0003),
			i_word(OP_BEQ, 5'd2, 5'd1, 16'hFFFF),
			i_word(OP_BEQ, 5'd0, 5'd0, 16'h8000),
			j_word(26'h3FF_FFFF),
			32'hFFFF_FFFF,
			{OP_RTYPE, 26'h3FF_FFFF},
			32'h0022_1000
		};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		fork
			take_results();
		join_none
		foreach (directed[i])
			send_word(directed[i], $urandom_range(0, 9));
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == 500) begin
				push <= 1'b0;
				do @(negedge clk); while (sb.outstanding() != 0);
			end
			gap = (i >= 240 && i < 330) ? 0 : $urandom_range(0, 9);
			send_word(random_word(), gap);
		end
		push <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/msec_pkg.sv
sv/msec_fifo.sv
sv/msec_front.sv
sv/msec_back.sv
sv/mips_subset_execute_core_top.sv
bench/mips_subset_execute_core_top_tb.sv
